FILE: rtl/core/hrt_pkg.sv
// Shared types and sizing constants for the handle registry table.
// Depends on nothing; imported by the controller and the top level.
package hrt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int MARK_W      = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W      = 10;
  localparam int HMARK_W     = 11;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_REMOVE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHRINK,
    ST_FIN
  } state_t;

  // Memory access issued by the controller in one cycle
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } ram_req_t;

endpackage

FILE: rtl/core/hrt_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// Depends on nothing.
module hrt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hrt_ctrl.sv
// Request sequencer: scans the slot memory, writes back, tracks the mark.
// Depends on hrt_pkg; drives the slot RAM through a ram_req_t bundle.
module hrt_ctrl
  import hrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [31:0]         in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [HMARK_W-1:0]  out_high_mark,
  output ram_req_t            ram_req,
  input  logic [KEY_BITS-1:0] ram_rdata
);

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [MARK_W-1:0]   mark_r, mark_nxt;
  logic [MARK_W-1:0]   ptr_r, ptr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [HMARK_W-1:0]  out_mark_r, out_mark_nxt;

  logic                accept;
  logic                out_free;
  logic [KEY_BITS-1:0] in_key_m;
  logic                scan_hit;
  logic                scan_done;
  logic                hit_at_top;
  logic                table_full;
  logic                rd_zero;

  assign in_key_m   = in_key[KEY_BITS-1:0];
  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign rd_zero    = (ram_rdata == '0);
  assign scan_hit   = rd_vld_r && ((op_r == REQ_REGISTER) ? rd_zero : (ram_rdata == key_r));
  assign scan_done  = !scan_hit && (ptr_r == mark_r);
  assign hit_at_top = ((MARK_W'(rd_idx_r) + MARK_W'(1)) == mark_r);
  assign table_full = (mark_r == MARK_W'(TABLE_DEPTH));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_key_m == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = (op_r == REQ_REMOVE && hit_at_top) ? ST_SHRINK : ST_FIN;
        end else if (scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_SHRINK: begin
        if (rd_vld_r) begin
          if (!rd_zero || mark_r == MARK_W'(1)) begin
            state_nxt = ST_FIN;
          end
        end else if (mark_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory access
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    mark_nxt      = mark_r;
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_mark_nxt  = out_mark_r;
    ram_req       = '0;
    ram_req.raddr = ptr_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        // Latch the request and start the scan from slot zero
        if (accept) begin
          op_nxt       = in_req_type;
          key_nxt      = in_key_m;
          ptr_nxt      = '0;
          res_ok_nxt   = 1'b0;
          res_slot_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          // First empty slot for register, first match for remove
          ram_req.we    = 1'b1;
          ram_req.waddr = rd_idx_r;
          ram_req.wdata = (op_r == REQ_REGISTER) ? key_r : '0;
          res_ok_nxt    = 1'b1;
          res_slot_nxt  = rd_idx_r;
          if (op_r == REQ_REMOVE && hit_at_top) begin
            mark_nxt = MARK_W'(rd_idx_r);
          end
        end else if (scan_done) begin
          // Register with no empty slot below the mark: append at the mark unless full
          if (op_r == REQ_REGISTER && !table_full) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = mark_r[IDX_W-1:0];
            ram_req.wdata = key_r;
            res_ok_nxt    = 1'b1;
            res_slot_nxt  = mark_r[IDX_W-1:0];
            mark_nxt      = mark_r + MARK_W'(1);
          end
        end else begin
          // Issue the next read while checking the previous one
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + MARK_W'(1);
        end
      end
      ST_SHRINK: begin
        // Walk the mark down past trailing empty slots
        if (rd_vld_r) begin
          if (rd_zero) begin
            mark_nxt = mark_r - MARK_W'(1);
            if (mark_r != MARK_W'(1)) begin
              ram_req.raddr = IDX_W'(mark_r - MARK_W'(2));
              rd_vld_nxt    = 1'b1;
            end
          end
        end else if (mark_r != '0) begin
          ram_req.raddr = IDX_W'(mark_r - MARK_W'(1));
          rd_vld_nxt    = 1'b1;
        end
      end
      ST_FIN: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_slot_nxt  = SLOT_W'(res_slot_r);
          out_mark_nxt  = HMARK_W'(mark_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mark_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mark_r      <= mark_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
    out_mark_r <= out_mark_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_slot      = out_slot_r;
  assign out_high_mark = out_mark_r;

  // Mark stays within the table
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= MARK_W'(TABLE_DEPTH))
    else $error("high-water mark beyond table depth");

  // Memory is written only while scanning
  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> state_r == ST_SCAN)
    else $error("slot write outside scan");

  // Mark moves by at most one per cycle
  a_mark_step: assert property (@(posedge clk) disable iff (!rst_n)
    (mark_r != $past(mark_r)) |->
      (mark_r == $past(mark_r) + MARK_W'(1) || mark_r == $past(mark_r) - MARK_W'(1)))
    else $error("high-water mark jumped");

  // A zero key goes straight to the result
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_key_m == '0) |=> state_r == ST_FIN && !res_ok_r)
    else $error("zero key not rejected");

  // A failed request reports slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_slot_r == '0)
    else $error("failed request with nonzero slot");

endmodule

FILE: rtl/core/handle_registry_table_unit.sv
// Flow: an accepted request scans the slots below the mark (at most TABLE_DEPTH), then
//   passes through ST_FIN into the output register; a zero key goes straight to ST_FIN.
//   A removal that frees the top slot first walks the mark down past trailing empty slots.
// Requests: one at a time; the single read port of the slot RAM reads one slot per cycle
//   during the scan. A new request is taken while the last result waits.
//   Reset clears the mark and the handshake; slots at or above the mark count as empty,
//   so no clearing pass.
module handle_registry_table_unit
  import hrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [31:0]        in_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [HMARK_W-1:0] out_high_mark
);

  ram_req_t            ram_req;
  logic [KEY_BITS-1:0] ram_rdata;

  // Sequencer
  hrt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_slot      (out_slot),
    .out_high_mark (out_high_mark),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata)
  );

  // Slot store
  hrt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for handle_registry_table_unit: directed rows, then random requests
// ending in a stretch with no idling. Depends on hrt_pkg and the top level of the block.
`timescale 1ns / 1ps

module testbench
  import hrt_pkg::*;
();

  localparam int          RANDOM_ITEMS = 560;
  localparam int          TAIL_ITEMS   = 60;
  localparam int          DRAIN_CYCLES = 3 * TABLE_DEPTH;
  localparam longint      CYCLE_LIMIT  = 20_000_000;
  localparam logic [31:0] KEY_MASK     = (KEY_BITS >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << KEY_BITS) - 1);

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic [HMARK_W-1:0]  mark;
  } reg_result_t;

  typedef struct packed {
    logic        req;
    logic [31:0] key;
    logic        has_literal;
    reg_result_t result;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 22;
  // Rows with has_literal set carry their result; the rest go to the predictor
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{REQ_REMOVE,   32'd5,         1'b1, '{1'b0, 10'd0, 11'd0}},  // missing, empty table
    '{REQ_REGISTER, 32'd0,         1'b1, '{1'b0, 10'd0, 11'd0}},  // zero key
    '{REQ_REMOVE,   32'd0,         1'b1, '{1'b0, 10'd0, 11'd0}},  // zero key
    '{REQ_REGISTER, 32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd0, 11'd1}},
    '{REQ_REGISTER, 32'd1,         1'b1, '{1'b1, 10'd1, 11'd2}},
    '{REQ_REGISTER, 32'h8000_0000, 1'b1, '{1'b1, 10'd2, 11'd3}},
    '{REQ_REGISTER, 32'd1,         1'b1, '{1'b1, 10'd3, 11'd4}},  // duplicate
    '{REQ_REMOVE,   32'd1,         1'b1, '{1'b1, 10'd1, 11'd4}},  // lowest copy first
    '{REQ_REMOVE,   32'd1,         1'b1, '{1'b1, 10'd3, 11'd3}},  // top slot, mark drops
    '{REQ_REGISTER, 32'd7,         1'b1, '{1'b1, 10'd1, 11'd3}},  // fills the hole
    '{REQ_REMOVE,   32'h8000_0000, 1'b1, '{1'b1, 10'd2, 11'd2}},
    '{REQ_REMOVE,   32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd0, 11'd2}},
    '{REQ_REMOVE,   32'd7,         1'b1, '{1'b1, 10'd1, 11'd0}},  // mark shrinks past two
    '{REQ_REMOVE,   32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, 11'd0}},
    '{REQ_REGISTER, 32'h5555_AAAA, 1'b1, '{1'b1, 10'd0, 11'd1}},
    '{REQ_REGISTER, 32'hAAAA_5555, 1'b1, '{1'b1, 10'd1, 11'd2}},
    '{REQ_REMOVE,   32'h1234_5678, 1'b1, '{1'b0, 10'd0, 11'd2}},  // missing key
    '{REQ_REGISTER, 32'd0,         1'b1, '{1'b0, 10'd0, 11'd2}},
    '{REQ_REGISTER, 32'd3,         1'b0, '0},
    '{REQ_REMOVE,   32'h5555_AAAA, 1'b0, '0},
    '{REQ_REMOVE,   32'hAAAA_5555, 1'b0, '0},
    '{REQ_REMOVE,   32'd3,         1'b0, '0}
  };

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               in_req_type   = REQ_REGISTER;
  logic [31:0]        in_key        = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               out_ok;
  logic [SLOT_W-1:0]  out_slot;
  logic [HMARK_W-1:0] out_high_mark;

  // Predictor state
  logic [31:0]        table_keys [TABLE_DEPTH];
  int unsigned        water_level = 0;

  reg_result_t        pending_results [$];
  int unsigned        error_count = 0;
  longint             cycle_count = 0;
  bit                 rx_stall_on = 1'b1;
  int unsigned        rx_stall_left = 0;

  handle_registry_table_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_slot      (out_slot),
    .out_high_mark (out_high_mark)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the table copy and return what the block should answer
  function automatic reg_result_t apply_request(input logic req, input logic [31:0] key_in);
    logic [31:0] k;
    reg_result_t r;
    bit          done;
    k    = key_in & KEY_MASK;
    r    = '0;
    done = 1'b0;
    if (k != 0) begin
      if (req == REQ_REGISTER) begin
        for (int i = 0; i < TABLE_DEPTH && !done; i++) begin
          if (table_keys[i] == 0) begin
            table_keys[i] = k;
            if (i == water_level) water_level++;
            r.ok   = 1'b1;
            r.slot = SLOT_W'(i);
            done   = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < TABLE_DEPTH && i < water_level && !done; i++) begin
          if (table_keys[i] == k) begin
            table_keys[i] = '0;
            while (water_level > 0 && table_keys[water_level - 1] == 0) water_level--;
            r.ok   = 1'b1;
            r.slot = SLOT_W'(i);
            done   = 1'b1;
          end
        end
      end
    end
    r.mark = HMARK_W'(water_level);
    return r;
  endfunction

  // Hold a request until accepted, log its expected result, then maybe idle
  task automatic send_request(input logic req, input logic [31:0] key, input bit allow_gap,
                              input bit use_literal, input reg_result_t literal);
    reg_result_t r;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_request(req, key);
    if (use_literal) r = literal;
    pending_results.push_back(r);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Check each result against the oldest expectation; drive stall bursts
  always @(posedge clk) begin
    reg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, ok %0d slot %0d mark %0d",
                 $time, out_ok, out_slot, out_high_mark);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok, out_ok);
          error_count++;
        end
        if (out_slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, out_slot);
          error_count++;
        end
        if (out_high_mark !== want.mark) begin
          $display("%0t: high_mark mismatch, expected %0d, got %0d",
                   $time, want.mark, out_high_mark);
          error_count++;
        end
      end
    end
    if (rx_stall_left != 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
      out_ready     <= 1'b0;
      rx_stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [31:0] key;
    logic        req;
    int          pick;
    bit          quiet;
    for (int i = 0; i < TABLE_DEPTH; i++) table_keys[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    for (int n = 0; n < DIRECTED_COUNT; n++) begin
      row = DIRECTED_ROWS[n];
      send_request(row.req, row.key, 1'b1, row.has_literal, row.result);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Random requests: small key pool for hits and duplicates, some wide and zero keys;
    // the last stretch runs with no idling on either side
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet       = (n >= 150 && n < 230) || (n >= RANDOM_ITEMS - TAIL_ITEMS);
      rx_stall_on = !quiet;
      if (n == 300) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) key = 32'($urandom_range(1, 15));
      else if (pick < 70) key = $urandom;
      else if (pick < 78) key = '0;
      else if (water_level != 0) key = table_keys[$urandom_range(0, water_level - 1)];
      else key = 32'($urandom_range(1, 15));
      // Lean toward removal once the mark climbs, keeping scans short
      if (water_level > 48) req = ($urandom_range(0, 3) != 0) ? REQ_REMOVE : REQ_REGISTER;
      else req = ($urandom_range(0, 1) != 0) ? REQ_REMOVE : REQ_REGISTER;
      send_request(req, key, !quiet, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain and let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
